// File: rtl/core/sgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_pkg: shared types and constants for the stream group reverser
// Word width, config width, reset values and the control state type.
// ----------------------------------------------------------------------------
package sgr_pkg;

  localparam int VALUE_W        = 32;
  localparam int CFG_W          = 5;
  localparam int MAX_GROUP_DEF  = 16;
  localparam int GROUP_SIZE_RST = 2;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } sgr_state_t;

endpackage

// File: rtl/core/stream_group_reverser_top.sv
`timescale 1ns / 1ps
// After a group's closing word is accepted, the state register enters drain and the first
//   word is then read into the buffer read register; a read waits while output is stalled.
//   A group fills at one word per cycle and drains at one buffer read per cycle when not
//   stalled; the single read port and fill-then-drain control keep input off during drain.
// Reset (rst_n low, synchronous): buffer empty, output idle, group_size = 2.
//   Buffer contents are not cleared; only entries written in the current group are read.
// ----------------------------------------------------------------------------
// stream_group_reverser_top: reverse words of a stream in groups of group_size
// Words are written into the group buffer as they arrive. When group_size words
// (clamped to 1..MAX_GROUP) are held, or the word marked last arrives, the group is
// read back reversed (full group) or in order (short leftover) and sent out, last
// flag on the final word of the list.
// ----------------------------------------------------------------------------
module stream_group_reverser_top #(
  parameter int MAX_GROUP = sgr_pkg::MAX_GROUP_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // config
  input  logic                        cfg_wr_en,
  input  logic [sgr_pkg::CFG_W-1:0]   cfg_wr_data,   // group_size
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [sgr_pkg::VALUE_W-1:0] in_tdata,      // [31:0] item_value
  input  logic                        in_tlast,      // item_last
  // output stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [sgr_pkg::VALUE_W-1:0] out_tdata,     // [31:0] out_value
  output logic                        out_tlast      // out_last
);

  // CW holds counts 0..MAX_GROUP, AW addresses the buffer
  localparam int CW = $clog2(MAX_GROUP + 1);
  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  sgr_pkg::sgr_state_t state_r, state_nxt;

  logic [sgr_pkg::CFG_W-1:0] group_size_r;
  logic [CW-1:0]             fill_r, fill_nxt;   // words held while filling
  logic [CW-1:0]             n_r, n_nxt;         // group length being drained
  logic [CW-1:0]             idx_r, idx_nxt;     // next output position
  logic                      rev_r, rev_nxt;     // drain reversed
  logic                      lst_r, lst_nxt;     // group closes the list
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_last_r, out_last_nxt;

  logic [CW-1:0] k_eff;
  logic [CW-1:0] fill_inc;
  logic          in_xact;
  logic          hit_k;
  logic          close_grp;
  logic          out_free;
  logic          rd_en;
  logic          wr_en;
  logic          last_rd;
  logic [CW-1:0] rev_pos;
  logic [AW-1:0] rd_addr;

  // ---- config register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= sgr_pkg::CFG_W'(sgr_pkg::GROUP_SIZE_RST);
    end else if (cfg_wr_en) begin
      group_size_r <= cfg_wr_data;
    end
  end

  // effective group size: zero acts as 1, saturates at MAX_GROUP
  always_comb begin
    if (32'(group_size_r) >= 32'(MAX_GROUP)) begin
      k_eff = CW'(MAX_GROUP);
    end else if (group_size_r == '0) begin
      k_eff = CW'(1);
    end else begin
      k_eff = CW'(group_size_r);
    end
  end

  // ---- fill side ----
  assign in_xact   = in_tvalid && in_tready;
  assign fill_inc  = fill_r + CW'(1);
  assign hit_k     = (fill_inc >= k_eff);
  assign close_grp = hit_k || in_tlast;

  // ---- drain side ----
  assign out_free = !out_valid_r || out_tready;
  assign last_rd  = (idx_r == (n_r - CW'(1)));
  assign rev_pos  = n_r - idx_r - CW'(1);
  assign rd_addr  = rev_r ? rev_pos[AW-1:0] : idx_r[AW-1:0];

  // ---- FSM: next state ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sgr_pkg::ST_FILL: begin
        if (in_xact && close_grp) begin
          state_nxt = sgr_pkg::ST_DRAIN;
        end
      end
      sgr_pkg::ST_DRAIN: begin
        if (rd_en && last_rd) begin
          state_nxt = sgr_pkg::ST_FILL;
        end
      end
      default: state_nxt = sgr_pkg::ST_FILL;
    endcase
  end

  // ---- FSM: outputs ----
  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    unique case (state_r)
      sgr_pkg::ST_FILL:  in_tready = 1'b1;
      sgr_pkg::ST_DRAIN: rd_en     = out_free;
      default: begin
        in_tready = 1'b0;
        rd_en     = 1'b0;
      end
    endcase
  end

  assign wr_en = in_xact;

  // ---- counters and output register next values ----
  always_comb begin
    fill_nxt      = fill_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    rev_nxt       = rev_r;
    lst_nxt       = lst_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;

    if (in_xact) begin
      if (close_grp) begin
        // group closes: latch its shape, start drain at position 0
        fill_nxt = '0;
        n_nxt    = fill_inc;
        idx_nxt  = '0;
        rev_nxt  = hit_k;
        lst_nxt  = in_tlast;
      end else begin
        fill_nxt = fill_inc;
      end
    end

    if (rd_en) begin
      idx_nxt       = idx_r + CW'(1);
      out_valid_nxt = 1'b1;
      out_last_nxt  = lst_r && last_rd;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sgr_pkg::ST_FILL;
      fill_r      <= '0;
      n_r         <= '0;
      idx_r       <= '0;
      rev_r       <= 1'b0;
      lst_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      n_r         <= n_nxt;
      idx_r       <= idx_nxt;
      rev_r       <= rev_nxt;
      lst_r       <= lst_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // ---- group buffer; its read register is the output data register ----
  sgr_buf #(
    .DEPTH (MAX_GROUP),
    .AW    (AW),
    .DW    (sgr_pkg::VALUE_W)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data (in_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (out_tdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  // buffer never overflows while filling
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sgr_pkg::ST_FILL) |-> (32'(fill_r) < 32'(MAX_GROUP)))
    else $error("fill count reached buffer depth while filling");

  // reads only during drain, and only inside the group
  a_rd_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> ((state_r == sgr_pkg::ST_DRAIN) && (idx_r < n_r)))
    else $error("buffer read outside a draining group");

  // fill count restarts when a drain begins
  a_drain_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sgr_pkg::ST_DRAIN) |-> (fill_r == '0))
    else $error("fill count not cleared during drain");

  // a read always refreshes the output register
  a_rd_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> out_valid_r)
    else $error("read issued but output not valid");
`endif

endmodule

// File: rtl/core/sgr_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_buf: group buffer
// Single write port, single read port, registered read data.
// Read data holds while rd_en is low.
// ----------------------------------------------------------------------------
module sgr_buf #(
  parameter int DEPTH = sgr_pkg::MAX_GROUP_DEF,
  parameter int AW    = 4,
  parameter int DW    = sgr_pkg::VALUE_W
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
